// ===== src/cpe_pkg.sv =====
// Shared types and constants of the min-cost max-flow engine.
// No dependencies; the engine top level and the testbench use it.
`default_nettype none
package cpe_pkg;
  localparam int NODES  = 64;
  localparam int NODE_W = 6;
  localparam int CNT_N_W = 7;
  localparam int CAP_W  = 16;
  localparam int COST_W = 17;
  localparam int DIST_W = 32;
  localparam int TOT_W  = 48;

  localparam logic [0:0] OP_ADD   = 1'b0;
  localparam logic [0:0] OP_SOLVE = 1'b1;

  localparam logic signed [DIST_W-1:0] DIST_INF = 32'sd1073741823;
  localparam logic [TOT_W-1:0] COST_MAX = {TOT_W{1'b1}};

  typedef struct packed {
    logic [NODE_W-1:0]        tail;
    logic [NODE_W-1:0]        head;
    logic [CAP_W-1:0]         cap;
    logic signed [COST_W-1:0] cost;
  } arc_t;
endpackage
`default_nettype wire

// ===== src/cpe_cmd_if.sv =====
// Command and result channel interfaces of the flow engine.
// Depend on nothing but plain logic types.
`default_nettype none
interface cpe_cmd_if;
  logic        valid;
  logic        ready;
  logic [0:0]  opcode;
  logic [5:0]  from_node;
  logic [5:0]  to_node;
  logic [15:0] capacity;
  logic [15:0] edge_cost;
  logic [5:0]  source_node;
  logic [5:0]  sink_node;
  logic [15:0] push_limit;
  modport source (output valid, opcode, from_node, to_node, capacity, edge_cost, source_node,
                  sink_node, push_limit, input ready);
  modport sink (input valid, opcode, from_node, to_node, capacity, edge_cost, source_node,
                sink_node, push_limit, output ready);
endinterface

interface cpe_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] flow_sent;
  logic [47:0] total_cost;
  logic        overflow;
  modport source (output valid, flow_sent, total_cost, overflow, input ready);
  modport sink (input valid, flow_sent, total_cost, overflow, output ready);
endinterface
`default_nettype wire

// ===== src/cpe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module cpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== src/min_cost_max_flow_engine_unit.sv =====
// Top level of the min-cost max-flow engine: control sequencer and its RAMs.
// Depends on cpe_pkg, cpe_cmd_if, cpe_rsp_if and cpe_ram.
//
// Use: items arrive on cmd (valid/ready). An add-edge item stores a forward
// arc and a zero-capacity reverse arc with the negated cost and gives no
// result. When the arc store is full the edge is dropped and the sticky
// overflow flag is set. A solve item runs successive shortest paths from
// source to sink: each round clears the node table (the node_count entries
// in use, at most 64), seeds the queue, runs a FIFO label-correcting search,
// walks the predecessor path twice and adds push times path cost. A solve
// with a source or sink not in use or a zero push limit ends at once; an
// unreachable sink or a negative cycle ends it with what was sent so far.
// The arc RAM, read one arc at a time, sets the pace of the search.
// One result item per solve goes out on rsp: flow, saturated cost, overflow.
// The result sits in an output register; the next item is taken while it
// waits, but a following solve holds its result until rsp is free.
// Reset (rst, synchronous) empties the arc store, clears overflow, sets
// node_count to 64 and drops any pending result. The user writes node_count
// via cfg_we/cfg_data only while the block is idle; the block does not enforce it.
`default_nettype none
module min_cost_max_flow_engine_unit #(
  parameter int MAX_EDGES = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_data,
  cpe_cmd_if.sink         cmd,
  cpe_rsp_if.source       rsp
);
  localparam int ARC_SLOTS = 2 * MAX_EDGES;
  localparam int ARC_W     = $clog2(ARC_SLOTS);
  localparam int CNT_W     = $clog2(ARC_SLOTS + 1);
  localparam int NW        = cpe_pkg::NODE_W;
  localparam int KW        = cpe_pkg::CNT_N_W;

  typedef struct packed {
    logic signed [cpe_pkg::DIST_W-1:0] path_cost;
    logic [ARC_W-1:0]                  pred;
    logic                              mark;
    logic [KW-1:0]                     times;
  } node_t;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_ADD   = 5'd1;
  localparam logic [4:0] S_INIT  = 5'd2;
  localparam logic [4:0] S_SEED  = 5'd3;
  localparam logic [4:0] S_POP   = 5'd4;
  localparam logic [4:0] S_POP2  = 5'd5;
  localparam logic [4:0] S_POP3  = 5'd6;
  localparam logic [4:0] S_SCAN  = 5'd7;
  localparam logic [4:0] S_SCAN2 = 5'd8;
  localparam logic [4:0] S_SCAN3 = 5'd9;
  localparam logic [4:0] S_CHK   = 5'd10;
  localparam logic [4:0] S_CHK2  = 5'd11;
  localparam logic [4:0] S_WALK  = 5'd12;
  localparam logic [4:0] S_WALK2 = 5'd13;
  localparam logic [4:0] S_WALK3 = 5'd14;
  localparam logic [4:0] S_AUG   = 5'd15;
  localparam logic [4:0] S_AUG2  = 5'd16;
  localparam logic [4:0] S_AUG3  = 5'd17;
  localparam logic [4:0] S_AUG4  = 5'd18;
  localparam logic [4:0] S_MUL   = 5'd19;
  localparam logic [4:0] S_ACC   = 5'd20;
  localparam logic [4:0] S_DONE  = 5'd21;

  logic [4:0] state;
  logic [CNT_W-1:0] arc_count;
  logic overflow;
  logic [6:0] node_count;
  logic [NW-1:0] e_from, e_to;
  logic [15:0] e_cost;
  logic [NW-1:0] src, snk;
  logic [15:0] limit, flow, push;
  logic [NW-1:0] v, u, hd;
  logic [KW-1:0] steps;
  logic [CNT_W-1:0] a_idx;
  logic signed [31:0] du, dist_t;
  logic signed [32:0] nd;
  logic [NW-1:0] qh, qt;
  logic [KW-1:0] qlen;
  logic [ARC_W-1:0] aug_arc;
  logic signed [48:0] prod;
  logic signed [49:0] acc;
  logic out_valid;
  logic [15:0] out_flow;
  logic [47:0] out_cost;
  logic out_ovf;

  // RAM ports
  logic arc_we;
  logic [ARC_W-1:0] arc_waddr, arc_raddr;
  cpe_pkg::arc_t arc_wdata, arc_rd;
  logic node_we;
  logic [NW-1:0] node_waddr, node_raddr;
  node_t node_wdata, node_rd;
  logic q_we;
  logic [NW-1:0] q_raddr;
  logic [NW-1:0] q_rd;

  cpe_ram #(.WIDTH($bits(cpe_pkg::arc_t)), .DEPTH(ARC_SLOTS)) u_arc_ram (
    .clk(clk), .we(arc_we), .waddr(arc_waddr), .wdata(arc_wdata),
    .raddr(arc_raddr), .rdata(arc_rd)
  );
  cpe_ram #(.WIDTH($bits(node_t)), .DEPTH(cpe_pkg::NODES)) u_node_ram (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_rd)
  );
  cpe_ram #(.WIDTH(NW), .DEPTH(cpe_pkg::NODES)) u_queue_ram (
    .clk(clk), .we(q_we), .waddr(qt), .wdata(q_we && state == S_SEED ? src : hd),
    .raddr(q_raddr), .rdata(q_rd)
  );

  // Nodes in use, clamped to the table size
  logic [6:0] n_use;
  assign n_use = (node_count > 7'(cpe_pkg::NODES)) ? 7'(cpe_pkg::NODES) : node_count;

  logic store_full;
  assign store_full = ({1'b0, arc_count} + (CNT_W+1)'(2)) > (CNT_W+1)'(ARC_SLOTS);

  logic arc_skip;
  assign arc_skip = (arc_rd.tail != u) || ({1'b0, arc_rd.head} >= n_use) || (arc_rd.cap == '0);

  logic relax, qfail;
  logic [KW:0] times_inc;
  assign relax = nd < $signed({node_rd.path_cost[31], node_rd.path_cost});
  assign times_inc = {1'b0, node_rd.times} + (KW+1)'(1);
  assign qfail = relax && !node_rd.mark && (times_inc > {1'b0, n_use});

  assign cmd.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.flow_sent = out_flow;
  assign rsp.total_cost = out_cost;
  assign rsp.overflow = out_ovf;

  // RAM addressing per sequencer step
  always_comb begin
    arc_we = 1'b0;
    arc_waddr = arc_count[ARC_W-1:0];
    arc_wdata = arc_rd;
    arc_raddr = a_idx[ARC_W-1:0];
    node_we = 1'b0;
    node_waddr = v;
    node_wdata = node_rd;
    node_raddr = v;
    q_we = 1'b0;
    q_raddr = qh;
    unique case (state)
      S_IDLE: begin
        if (cmd.valid && cmd.opcode == cpe_pkg::OP_ADD && !store_full) begin
          arc_we = 1'b1;
          arc_wdata.tail = cmd.from_node;
          arc_wdata.head = cmd.to_node;
          arc_wdata.cap = cmd.capacity;
          arc_wdata.cost = $signed({1'b0, cmd.edge_cost});
        end
      end
      S_ADD: begin
        arc_we = 1'b1;
        arc_waddr = ARC_W'(arc_count + CNT_W'(1));
        arc_wdata.tail = e_to;
        arc_wdata.head = e_from;
        arc_wdata.cap = '0;
        arc_wdata.cost = -$signed({1'b0, e_cost});
      end
      S_INIT: begin
        node_we = 1'b1;
        node_wdata = '{path_cost: cpe_pkg::DIST_INF, pred: '0, mark: 1'b0, times: '0};
      end
      S_SEED: begin
        node_we = 1'b1;
        node_waddr = src;
        node_wdata = '{path_cost: '0, pred: '0, mark: 1'b1, times: KW'(1)};
        q_we = 1'b1;
      end
      S_POP2: node_raddr = q_rd;
      S_POP3: begin
        node_we = 1'b1;
        node_waddr = u;
        node_wdata.mark = 1'b0;
      end
      S_SCAN2: node_raddr = arc_rd.head;
      S_SCAN3: begin
        if (relax && !qfail) begin
          node_we = 1'b1;
          node_waddr = hd;
          node_wdata = '{path_cost: nd[31:0], pred: a_idx[ARC_W-1:0], mark: 1'b1,
                         times: node_rd.mark ? node_rd.times : times_inc[KW-1:0]};
          q_we = !node_rd.mark;
        end
      end
      S_CHK: node_raddr = snk;
      S_WALK2: arc_raddr = node_rd.pred;
      S_AUG2: arc_raddr = node_rd.pred;
      S_AUG3: begin
        arc_we = 1'b1;
        arc_waddr = aug_arc;
        arc_wdata.cap = arc_rd.cap - push;
        arc_raddr = aug_arc ^ ARC_W'(1);
      end
      S_AUG4: begin
        arc_we = 1'b1;
        arc_waddr = aug_arc ^ ARC_W'(1);
        arc_wdata.cap = arc_rd.cap + push;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      arc_count <= '0;
      overflow <= 1'b0;
      node_count <= 7'd64;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count <= cfg_data;
      end
      // a result loaded in S_DONE takes over the register in the same cycle
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            e_from <= cmd.from_node;
            e_to <= cmd.to_node;
            e_cost <= cmd.edge_cost;
            src <= cmd.source_node;
            snk <= cmd.sink_node;
            limit <= cmd.push_limit;
            flow <= '0;
            acc <= '0;
            v <= '0;
            if (cmd.opcode == cpe_pkg::OP_ADD) begin
              // drop the edge when both arcs do not fit
              if (store_full) begin
                overflow <= 1'b1;
              end else begin
                state <= S_ADD;
              end
            end else if ({1'b0, cmd.source_node} < n_use && {1'b0, cmd.sink_node} < n_use &&
                         cmd.push_limit != '0) begin
              state <= S_INIT;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_ADD: begin
          arc_count <= arc_count + CNT_W'(2);
          state <= S_IDLE;
        end
        S_INIT: begin
          v <= v + NW'(1);
          if ({1'b0, v} == n_use - 7'd1) begin
            // empty the work queue so the seed lands in slot zero
            qh <= '0;
            qt <= '0;
            state <= S_SEED;
          end
        end
        S_SEED: begin
          qh <= '0;
          qt <= NW'(1);
          qlen <= KW'(1);
          state <= S_POP;
        end
        S_POP: begin
          if (qlen == '0) begin
            state <= S_CHK;
          end else begin
            qh <= qh + NW'(1);
            qlen <= qlen - KW'(1);
            state <= S_POP2;
          end
        end
        S_POP2: begin
          u <= q_rd;
          state <= S_POP3;
        end
        S_POP3: begin
          du <= node_rd.path_cost;
          a_idx <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          state <= (a_idx == arc_count) ? S_POP : S_SCAN2;
        end
        S_SCAN2: begin
          hd <= arc_rd.head;
          nd <= $signed({du[31], du}) + 33'(arc_rd.cost);
          if (arc_skip) begin
            a_idx <= a_idx + CNT_W'(1);
            state <= S_SCAN;
          end else begin
            state <= S_SCAN3;
          end
        end
        S_SCAN3: begin
          if (qfail) begin
            // negative cycle: abandon the search, keep what was sent
            state <= S_DONE;
          end else begin
            if (relax) begin
              if (hd == u) begin
                du <= nd[31:0];
              end
              if (!node_rd.mark) begin
                qt <= qt + NW'(1);
                qlen <= qlen + KW'(1);
              end
            end
            a_idx <= a_idx + CNT_W'(1);
            state <= S_SCAN;
          end
        end
        S_CHK: state <= S_CHK2;
        S_CHK2: begin
          if (node_rd.path_cost >= cpe_pkg::DIST_INF) begin
            state <= S_DONE;
          end else begin
            dist_t <= node_rd.path_cost;
            push <= limit - flow;
            v <= snk;
            steps <= '0;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (v == src) begin
            v <= snk;
            state <= S_AUG;
          end else if (steps == n_use) begin
            state <= S_DONE;
          end else begin
            state <= S_WALK2;
          end
        end
        S_WALK2: state <= S_WALK3;
        S_WALK3: begin
          if (arc_rd.cap < push) begin
            push <= arc_rd.cap;
          end
          v <= arc_rd.tail;
          steps <= steps + KW'(1);
          state <= S_WALK;
        end
        S_AUG: state <= (v == src) ? S_MUL : S_AUG2;
        S_AUG2: begin
          aug_arc <= node_rd.pred;
          state <= S_AUG3;
        end
        S_AUG3: begin
          v <= arc_rd.tail;
          state <= S_AUG4;
        end
        S_AUG4: state <= S_AUG;
        S_MUL: begin
          flow <= flow + push;
          prod <= $signed({1'b0, push}) * dist_t;
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= acc + {prod[48], prod};
          v <= '0;
          state <= (flow < limit) ? S_INIT : S_DONE;
        end
        S_DONE: begin
          // hold the result until the output register is free
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_flow <= flow;
            out_ovf <= overflow;
            if (acc < 0) begin
              out_cost <= '0;
            end else if (acc > $signed({2'b00, cpe_pkg::COST_MAX})) begin
              out_cost <= cpe_pkg::COST_MAX;
            end else begin
              out_cost <= acc[47:0];
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_arc_count_even: assert property (@(posedge clk) disable iff (rst) arc_count[0] == 1'b0)
    else $error("arc count odd");
  a_arc_count_bound: assert property (@(posedge clk) disable iff (rst)
      arc_count <= CNT_W'(ARC_SLOTS))
    else $error("arc count beyond store");
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
      (state == S_POP) |-> (qlen <= KW'(cpe_pkg::NODES)))
    else $error("work queue overrun");
  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
      overflow |=> overflow)
    else $error("overflow flag cleared");
endmodule
`default_nettype wire

// ===== dv/tb_min_cost_max_flow_engine_unit.sv =====
// Testbench of min_cost_max_flow_engine_unit: directed and random edge/solve items,
// each solve result checked against a behavioral flow predictor.
// Depends on cpe_pkg, cpe_cmd_if, cpe_rsp_if and the engine top level.
`timescale 1ns / 1ps
module tb_min_cost_max_flow_engine_unit;

  localparam int ARC_SLOTS = 512;
  localparam longint UNREACHED = 64'sd1073741823;
  localparam longint TOTAL_CEIL = (64'sd1 <<< 48) - 1;

  typedef struct {
    logic [0:0]  opcode;
    logic [5:0]  from_node;
    logic [5:0]  to_node;
    logic [15:0] capacity;
    logic [15:0] edge_cost;
    logic [5:0]  source;
    logic [5:0]  sink;
    logic [15:0] push_limit;
  } flow_cmd_t;

  typedef struct {
    logic [15:0] flow_sent;
    logic [47:0] total_cost;
    logic        overflow;
  } flow_rsp_t;

  // Residual graph mirror plus the queue of solve results still owed by the block.
  class flow_scoreboard;
    int unsigned arc_tail[ARC_SLOTS];
    int unsigned arc_head[ARC_SLOTS];
    int unsigned arc_cap[ARC_SLOTS];
    int          arc_cost[ARC_SLOTS];
    int unsigned arcs_used;
    bit          dropped;
    int unsigned nodes;
    longint      reach_cost[64];
    int unsigned via_arc[64];
    flow_rsp_t   owed[$];
    int          errors;

    function new();
      nodes = 64;
    endfunction

    // FIFO label-correcting search; 0 when a negative cycle aborts it.
    function bit cheapest_paths(int unsigned s, int unsigned n);
      int unsigned fifo[64];
      bit          queued[64];
      int unsigned visits[64];
      int unsigned qh, qt, qlen, u, h;
      longint      nd;
      for (int v = 0; v < n; v++) begin
        reach_cost[v] = UNREACHED;
        queued[v] = 0;
        visits[v] = 0;
        via_arc[v] = 0;
      end
      reach_cost[s] = 0;
      fifo[0] = s;
      qh = 0;
      qt = 1;
      qlen = 1;
      queued[s] = 1;
      visits[s] = 1;
      while (qlen > 0) begin
        u = fifo[qh];
        qh = (qh + 1) % 64;
        qlen--;
        queued[u] = 0;
        for (int a = 0; a < arcs_used; a++) begin
          h = arc_head[a];
          if (arc_tail[a] != u || h >= n || arc_cap[a] == 0) continue;
          nd = reach_cost[u] + arc_cost[a];
          if (nd < reach_cost[h]) begin
            reach_cost[h] = nd;
            via_arc[h] = a;
            if (!queued[h]) begin
              visits[h]++;
              if (visits[h] > n) return 0;
              queued[h] = 1;
              fifo[qt] = h;
              qt = (qt + 1) % 64;
              qlen++;
            end
          end
        end
      end
      return 1;
    endfunction

    function void note_input(flow_cmd_t c);
      int unsigned n, flow, lim, push, v, steps, a;
      longint      acc;
      flow_rsp_t   r;
      if (c.opcode == cpe_pkg::OP_ADD) begin
        if (arcs_used + 2 > ARC_SLOTS) begin
          dropped = 1;
          return;
        end
        arc_tail[arcs_used] = c.from_node;
        arc_head[arcs_used] = c.to_node;
        arc_cap[arcs_used] = c.capacity;
        arc_cost[arcs_used] = int'(c.edge_cost);
        arc_tail[arcs_used + 1] = c.to_node;
        arc_head[arcs_used + 1] = c.from_node;
        arc_cap[arcs_used + 1] = 0;
        arc_cost[arcs_used + 1] = -int'(c.edge_cost);
        arcs_used += 2;
        return;
      end
      n = (nodes > 64) ? 64 : nodes;
      flow = 0;
      acc = 0;
      lim = c.push_limit;
      if (c.source < n && c.sink < n) begin
        while (flow < lim) begin
          if (!cheapest_paths(c.source, n) || reach_cost[c.sink] >= UNREACHED) break;
          push = lim - flow;
          v = c.sink;
          steps = 0;
          while (v != c.source && steps < n) begin
            a = via_arc[v];
            if (arc_cap[a] < push) push = arc_cap[a];
            v = arc_tail[a];
            steps++;
          end
          if (v != c.source) break;
          v = c.sink;
          while (v != c.source) begin
            a = via_arc[v];
            arc_cap[a] -= push;
            arc_cap[a ^ 1] += push;
            v = arc_tail[a];
          end
          flow += push;
          acc += longint'(push) * reach_cost[c.sink];
        end
      end
      if (acc < 0) acc = 0;
      if (acc > TOTAL_CEIL) acc = TOTAL_CEIL;
      r.flow_sent = flow[15:0];
      r.total_cost = acc[47:0];
      r.overflow = dropped;
      owed = {owed, r};
    endfunction

    function void check(flow_rsp_t got);
      flow_rsp_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: flow %0d cost %0d ovf %0d",
                                   got.flow_sent, got.total_cost, got.overflow);
        return;
      end
      want = owed.pop_front();
      if (got.flow_sent !== want.flow_sent || got.total_cost !== want.total_cost ||
          got.overflow !== want.overflow) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: flow %0d/%0d cost %0d/%0d ovf %0d/%0d (exp/act)",
                   want.flow_sent, got.flow_sent, want.total_cost, got.total_cost,
                   want.overflow, got.overflow);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [6:0] cfg_data;

  cpe_cmd_if cmd ();
  cpe_rsp_if rsp ();

  min_cost_max_flow_engine_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .rsp      (rsp)
  );

  flow_scoreboard sb = new();

  // Knobs shared by the sender, the receiver and the sequence below.
  int unsigned burst_left;
  bit          sender_steady;
  int          rsp_mode;
  bit          long_hold_req;
  int unsigned rsp_beat;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watch both handshakes at the edge; feed the predictor and the checker.
  always @(posedge clk) begin
    flow_cmd_t c;
    flow_rsp_t r;
    if (!rst) begin
      if (cmd.valid && cmd.ready) begin
        c.opcode = cmd.opcode;
        c.from_node = cmd.from_node;
        c.to_node = cmd.to_node;
        c.capacity = cmd.capacity;
        c.edge_cost = cmd.edge_cost;
        c.source = cmd.source_node;
        c.sink = cmd.sink_node;
        c.push_limit = cmd.push_limit;
        sb.note_input(c);
      end
      if (rsp.valid && rsp.ready) begin
        r.flow_sent = rsp.flow_sent;
        r.total_cost = rsp.total_cost;
        r.overflow = rsp.overflow;
        sb.check(r);
      end
    end
  end

  // Receiver: its own stall pattern, plus one long hold-off counted here.
  initial begin
    rsp.ready <= 1'b0;
    rsp_beat = 0;
    forever begin
      @(posedge clk);
      rsp_beat++;
      if (long_hold_req) begin
        rsp.ready <= 1'b0;
        repeat (3000) @(posedge clk);
        long_hold_req = 0;
      end else begin
        case (rsp_mode)
          0: begin
            rsp.ready <= 1'b1;
          end
          1: begin
            rsp.ready <= ($urandom_range(0, 99) < 55);
          end
          default: begin
            rsp.ready <= ((rsp_beat % 11) < 4);
          end
        endcase
      end
    end
  end

  // Offer one item; hold valid until it is taken. Gaps fall between bursts.
  task automatic send_item(flow_cmd_t c);
    if (burst_left == 0) begin
      if (!sender_steady) begin
        cmd.valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    cmd.valid <= 1'b1;
    cmd.opcode <= c.opcode;
    cmd.from_node <= c.from_node;
    cmd.to_node <= c.to_node;
    cmd.capacity <= c.capacity;
    cmd.edge_cost <= c.edge_cost;
    cmd.source_node <= c.source;
    cmd.sink_node <= c.sink;
    cmd.push_limit <= c.push_limit;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    burst_left--;
  endtask

  // Stop offering and wait until every owed result is back, then let a
  // trailing add-edge item finish. The owed queue is checked only once
  // the monitor has noted the last accepted item.
  task automatic drain();
    cmd.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_node_count(int unsigned v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v[6:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.nodes = v;
    @(posedge clk);
  endtask

  function automatic flow_cmd_t edge_item(int f, int t, int cap, int cost);
    flow_cmd_t c;
    c.opcode = cpe_pkg::OP_ADD;
    c.from_node = 6'(f);
    c.to_node = 6'(t);
    c.capacity = 16'(cap);
    c.edge_cost = 16'(cost);
    c.source = 6'($urandom());
    c.sink = 6'($urandom());
    c.push_limit = 16'($urandom());
    return c;
  endfunction

  function automatic flow_cmd_t solve_item(int s, int t, int lim);
    flow_cmd_t c;
    c.opcode = cpe_pkg::OP_SOLVE;
    c.from_node = 6'($urandom());
    c.to_node = 6'($urandom());
    c.capacity = 16'($urandom());
    c.edge_cost = 16'($urandom());
    c.source = 6'(s);
    c.sink = 6'(t);
    c.push_limit = 16'(lim);
    return c;
  endfunction

  // Mostly nodes in use; now and then any node, to hit the unused-node paths.
  function automatic int pick_node(int n);
    if (n == 0 || $urandom_range(0, 99) < 12) return $urandom_range(0, 63);
    return $urandom_range(0, (n > 64 ? 64 : n) - 1);
  endfunction

  function automatic int pick_16(int lo, int hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 10) return 65535;
    if (r < 20) return $urandom_range(0, 65535);
    return $urandom_range(lo, hi);
  endfunction

  function automatic flow_cmd_t random_item(int n, int add_pct);
    if ($urandom_range(0, 99) < add_pct)
      return edge_item(pick_node(n), pick_node(n), pick_16(1, 30), pick_16(0, 40));
    return solve_item(pick_node(n), pick_node(n), pick_16(1, 60));
  endfunction

  // Random phases: node count, item count, share of add-edge items.
  int phase_nodes[10] = '{64, 127, 4, 6, 1, 3, 5, 2, 0, 7};
  int phase_items[10] = '{50, 40, 70, 70, 30, 80, 80, 60, 20, 30};
  int phase_adds[10]  = '{70, 60, 60, 85, 50, 70, 50, 40, 50, 50};

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    cmd.valid <= 1'b0;
    cmd.opcode <= cpe_pkg::OP_ADD;
    cmd.from_node <= '0;
    cmd.to_node <= '0;
    cmd.capacity <= '0;
    cmd.edge_cost <= '0;
    cmd.source_node <= '0;
    cmd.sink_node <= '0;
    cmd.push_limit <= '0;
    burst_left = 0;
    sender_steady = 1;
    rsp_mode = 0;
    long_hold_req = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: plain paths, zero-capacity edge, extreme nodes and values.
    send_item(edge_item(0, 1, 10, 3));
    send_item(edge_item(1, 2, 5, 4));
    send_item(edge_item(0, 2, 65535, 65535));
    send_item(edge_item(0, 3, 0, 0));
    send_item(edge_item(63, 62, 65535, 0));
    send_item(solve_item(0, 2, 65535));
    send_item(solve_item(0, 2, 0));
    send_item(solve_item(5, 5, 7));
    send_item(solve_item(63, 62, 65535));
    send_item(solve_item(10, 11, 9));
    send_item(solve_item(0, 3, 4));
    // Sink outside the node count, then a tiny graph.
    write_node_count(2);
    send_item(solve_item(0, 3, 4));
    send_item(solve_item(0, 1, 3));
    // No node in use at all.
    write_node_count(0);
    send_item(solve_item(0, 0, 5));
    // Above the node limit acts as the limit.
    write_node_count(127);
    send_item(solve_item(63, 62, 100));
    // Residual reverse arcs plus a cheap shortcut close a negative cycle.
    send_item(edge_item(0, 2, 5, 1));
    send_item(edge_item(2, 0, 5, 0));
    send_item(solve_item(0, 7, 5));
    send_item(solve_item(0, 2, 20));
    write_node_count(64);

    for (int p = 0; p < 10; p++) begin
      write_node_count(phase_nodes[p]);
      sender_steady = (p % 3 == 0);
      rsp_mode = p % 3;
      if (p == 2) long_hold_req = 1;
      for (int i = 0; i < phase_items[p]; i++)
        send_item(random_item(phase_nodes[p], phase_adds[p]));
    end

    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Run cap, far above the slowest correct run.
  initial begin
    #3s;
    $display("Verification failed");
    $finish;
  end
endmodule

// ===== sim.f =====
src/cpe_pkg.sv
src/cpe_cmd_if.sv
src/cpe_ram.sv
src/min_cost_max_flow_engine_unit.sv
dv/tb_min_cost_max_flow_engine_unit.sv
